[rtl/ftd_pkg.sv]
// Shared types and constants for the float to decimal text converter.
// Holds the request and result records and the field layout; depends on nothing.
package ftd_pkg;

  localparam int TEXT_BUFFER_BYTES_DEF   = 15;
  localparam int MAX_FRACTION_DIGITS_DEF = 7;
  localparam int RESULT_LIMIT            = 14;
  localparam int QUEUE_DEPTH             = 2;

  localparam int EXP_BIAS   = 127;
  localparam int EXP_MAX    = 31;
  localparam int EXP_MIN    = -23;
  localparam int FRAC_BITS  = 24;
  localparam int IPART_BITS = 31;
  localparam int INT_DIGITS = 10;
  localparam int DIG_W      = 4;
  localparam int IDX_W      = $clog2(INT_DIGITS);
  localparam int CHAR_W     = 7;
  localparam int WORD_W     = 32;

  localparam logic [7:0] EF_LARGE    = 8'(EXP_BIAS + EXP_MAX);
  localparam logic [7:0] EF_SMALL    = 8'(EXP_BIAS + EXP_MIN);
  localparam logic [7:0] EF_INT_ONLY = 8'(EXP_BIAS + FRAC_BITS - 1);
  localparam logic [7:0] EF_ONE      = 8'(EXP_BIAS);

  localparam logic [CHAR_W-1:0] CH_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LARGE = 2'd1,
    ST_SMALL = 2'd2
  } ftd_status_e;

  typedef struct packed {
    ftd_status_e            status;
    logic                   neg;
    logic [IPART_BITS-1:0]  ipart;
    logic [FRAC_BITS-1:0]   frac;
  } ftd_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    ftd_status_e       status;
  } ftd_result_t;

endpackage

[rtl/ftd_fifo.sv]
// Small first-in first-out queue of fixed-width words with a registered store.
// Used between the front and back parts and on the result side; no package needed.
module ftd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/ftd_front.sv]
// Front part: takes each single-precision word, classifies it and splits it into
// integer and fraction parts, then queues the request. Uses ftd_pkg and ftd_fifo.
module ftd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ftd_pkg::WORD_W-1:0]  float_bits_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic                        mid_pop_i,
  output logic                        mid_empty_o,
  output ftd_pkg::ftd_item_t          mid_item_o
);
  import ftd_pkg::*;

  logic [7:0]           efield;
  logic [FRAC_BITS-1:0] mant;
  ftd_item_t            item;
  logic [$bits(ftd_item_t)-1:0] mid_raw;

  assign efield = float_bits_i[30:23];
  assign mant   = {1'b1, float_bits_i[22:0]};

  always_comb begin
    item.status = ST_OK;
    item.neg    = float_bits_i[31];
    item.ipart  = '0;
    item.frac   = '0;
    if (float_bits_i[30:0] == '0) begin
      item.neg = 1'b0;
    end else if (efield >= EF_LARGE) begin
      item.status = ST_LARGE;
    end else if (efield < EF_SMALL) begin
      item.status = ST_SMALL;
    end else if (efield >= EF_INT_ONLY) begin
      item.ipart = IPART_BITS'(mant) << 3'(efield - EF_INT_ONLY);
    end else if (efield >= EF_ONE) begin
      item.ipart = IPART_BITS'(mant >> 5'(EF_INT_ONLY - efield));
      item.frac  = mant << 5'(efield - EF_ONE + 8'd1);
    end else begin
      item.frac = mant >> 5'(EF_ONE - 8'd1 - efield);
    end
  end

  ftd_fifo #(
    .WIDTH ($bits(ftd_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item),
    .full_o  (full_o),
    .pop_i   (mid_pop_i),
    .data_o  (mid_raw),
    .empty_o (mid_empty_o)
  );

  assign mid_item_o = ftd_item_t'(mid_raw);

endmodule

[rtl/ftd_back.sv]
// Back part: converts a queued request to decimal digits by shift-and-add-three
// and repeated times-ten steps, then emits the text. Uses ftd_pkg and ftd_fifo.
module ftd_back #(
  parameter int TEXT_BUFFER_BYTES   = ftd_pkg::TEXT_BUFFER_BYTES_DEF,
  parameter int MAX_FRACTION_DIGITS = ftd_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mid_empty_i,
  input  ftd_pkg::ftd_item_t   mid_item_i,
  output logic                 mid_pop_o,
  input  logic                 res_pop_i,
  output logic                 res_empty_o,
  output ftd_pkg::ftd_result_t res_o
);
  import ftd_pkg::*;

  localparam int CNT_W = $clog2(IPART_BITS);
  localparam int FW    = $clog2(MAX_FRACTION_DIGITS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CONV = 8'b0000_0010,
    S_SIZE = 8'b0000_0100,
    S_SIGN = 8'b0000_1000,
    S_INT  = 8'b0001_0000,
    S_DOT  = 8'b0010_0000,
    S_FRAC = 8'b0100_0000,
    S_ERR  = 8'b1000_0000
  } state_e;

  state_e                              state_q, state_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic [IPART_BITS-1:0]               ishift_q, ishift_d;
  logic [INT_DIGITS-1:0][DIG_W-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [FRAC_BITS-1:0]                frac_q, frac_d;
  logic [DIG_W-1:0]                    fdig_q [MAX_FRACTION_DIGITS];
  logic                                neg_q, neg_d;
  ftd_status_e                         status_q, status_d;
  logic [IDX_W-1:0]                    icur_q, icur_d;
  logic [FW-1:0]                       flast_q, flast_d;
  logic [FW-1:0]                       fcur_q, fcur_d;

  logic [FRAC_BITS+DIG_W-1:0]          prod;
  logic [IDX_W-1:0]                    top;
  logic [4:0]                          n_lead;
  logic [5:0]                          room_buf, room_res, maxd;
  logic [FW-1:0]                       lastnz;
  logic [DIG_W-1:0]                    int_digit, frac_digit;
  logic                                emit, res_push, res_full;
  ftd_result_t                         res_wdata;
  logic [$bits(ftd_result_t)-1:0]      res_raw;

  assign prod = (FRAC_BITS + DIG_W)'(frac_q) * (FRAC_BITS + DIG_W)'(10);

  always_comb begin
    for (int k = 0; k < INT_DIGITS; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end

  always_comb begin
    top = '0;
    for (int k = 0; k < INT_DIGITS; k++) begin
      if (bcd_q[k] != '0) begin
        top = IDX_W'(k);
      end
    end
    n_lead   = 5'(neg_q) + 5'(top) + 5'd2;
    room_buf = (6'(TEXT_BUFFER_BYTES) > 6'(n_lead) + 6'd1)
             ? 6'(TEXT_BUFFER_BYTES) - 6'(n_lead) - 6'd1 : 6'd0;
    room_res = 6'(RESULT_LIMIT) - 6'(n_lead);
    maxd     = 6'(MAX_FRACTION_DIGITS);
    if (room_buf < maxd) begin
      maxd = room_buf;
    end
    if (room_res < maxd) begin
      maxd = room_res;
    end
    lastnz = '0;
    for (int i = 0; i < MAX_FRACTION_DIGITS; i++) begin
      if ((6'(i) < maxd) && (fdig_q[i] != '0)) begin
        lastnz = FW'(i);
      end
    end
  end

  always_comb begin
    int_digit = '0;
    for (int k = 0; k < INT_DIGITS; k++) begin
      if (icur_q == IDX_W'(k)) begin
        int_digit = bcd_q[k];
      end
    end
    frac_digit = '0;
    for (int i = 0; i < MAX_FRACTION_DIGITS; i++) begin
      if (fcur_q == FW'(i)) begin
        frac_digit = fdig_q[i];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ishift_d  = ishift_q;
    bcd_d     = bcd_q;
    frac_d    = frac_q;
    neg_d     = neg_q;
    status_d  = status_q;
    icur_d    = icur_q;
    flast_d   = flast_q;
    fcur_d    = fcur_q;
    mid_pop_o = 1'b0;
    emit      = 1'b0;
    res_wdata.ch     = CH_NONE;
    res_wdata.last   = 1'b0;
    res_wdata.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (!mid_empty_i) begin
          mid_pop_o = 1'b1;
          neg_d     = mid_item_i.neg;
          status_d  = mid_item_i.status;
          ishift_d  = mid_item_i.ipart;
          frac_d    = mid_item_i.frac;
          bcd_d     = '0;
          cnt_d     = '0;
          state_d   = (mid_item_i.status == ST_OK) ? S_CONV : S_ERR;
        end
      end
      S_CONV: begin
        bcd_d    = (INT_DIGITS * DIG_W)'({bcd_adj, ishift_q[IPART_BITS-1]});
        ishift_d = ishift_q << 1;
        frac_d   = prod[FRAC_BITS-1:0];
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(IPART_BITS - 1)) begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        icur_d  = top;
        flast_d = lastnz;
        fcur_d  = '0;
        state_d = neg_q ? S_SIGN : S_INT;
      end
      S_SIGN: begin
        emit         = 1'b1;
        res_wdata.ch = CH_MINUS;
        if (!res_full) begin
          state_d = S_INT;
        end
      end
      S_INT: begin
        emit         = 1'b1;
        res_wdata.ch = CH_ZERO + CHAR_W'(int_digit);
        if (!res_full) begin
          if (icur_q == '0) begin
            state_d = S_DOT;
          end else begin
            icur_d = icur_q - 1'b1;
          end
        end
      end
      S_DOT: begin
        emit         = 1'b1;
        res_wdata.ch = CH_DOT;
        if (!res_full) begin
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        emit           = 1'b1;
        res_wdata.ch   = CH_ZERO + CHAR_W'(frac_digit);
        res_wdata.last = (fcur_q == flast_q);
        if (!res_full) begin
          if (fcur_q == flast_q) begin
            state_d = S_IDLE;
          end else begin
            fcur_d = fcur_q + 1'b1;
          end
        end
      end
      S_ERR: begin
        emit           = 1'b1;
        res_wdata.last = 1'b1;
        if (!res_full) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_push = emit & ~res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    ishift_q <= ishift_d;
    bcd_q    <= bcd_d;
    frac_q   <= frac_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    icur_q   <= icur_d;
    flast_q  <= flast_d;
    fcur_q   <= fcur_d;
    if (state_q == S_CONV) begin
      for (int i = 0; i < MAX_FRACTION_DIGITS; i++) begin
        if (cnt_q == CNT_W'(i)) begin
          fdig_q[i] <= prod[FRAC_BITS+DIG_W-1:FRAC_BITS];
        end
      end
    end
  end

  ftd_fifo #(
    .WIDTH ($bits(ftd_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_raw),
    .empty_o (res_empty_o)
  );

  assign res_o = ftd_result_t'(res_raw);

  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR) |-> (status_q != ST_OK))
    else $error("error result requested for a convertible value");

  a_int_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT) |-> (int_digit <= 4'd9))
    else $error("integer digit is not a decimal digit");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRAC) |-> (fcur_q <= flast_q))
    else $error("fraction cursor ran past the last digit");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop_o |=> (state_q == S_CONV || state_q == S_ERR))
    else $error("request taken without starting a conversion");

endmodule

[rtl/float_to_decimal_text.sv]
// Channel  | Direction | Handshake       | Payload
// request  | in        | push / full     | float_bits_i
// result   | out       | empty / pop     | out_char_o, last_char_o, conv_status_o
//
// A request is converted by 31 shift-and-add-three steps in the back part, plus load
// and sizing, then emitted at one character per cycle while the result queue has room.
// A two-entry queue in front and another on the result side let both sides stall alone.
// Reset is asynchronous and active low; it empties both queues and idles the back part.
// A full result queue holds the back part in place without losing a character.
module float_to_decimal_text #(
  parameter int TEXT_BUFFER_BYTES   = ftd_pkg::TEXT_BUFFER_BYTES_DEF,
  parameter int MAX_FRACTION_DIGITS = ftd_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ftd_pkg::WORD_W-1:0]  float_bits_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ftd_pkg::CHAR_W-1:0]  out_char_o,
  output logic                        last_char_o,
  output logic [1:0]                  conv_status_o
);
  import ftd_pkg::*;

  logic        mid_pop, mid_empty;
  ftd_item_t   mid_item;
  ftd_result_t res;

  ftd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .float_bits_i (float_bits_i),
    .push_i       (push),
    .full_o       (full),
    .mid_pop_i    (mid_pop),
    .mid_empty_o  (mid_empty),
    .mid_item_o   (mid_item)
  );

  ftd_back #(
    .TEXT_BUFFER_BYTES   (TEXT_BUFFER_BYTES),
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_item),
    .mid_pop_o   (mid_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign out_char_o    = res.ch;
  assign last_char_o   = res.last;
  assign conv_status_o = res.status;

endmodule

[verif/float_to_decimal_text_test.sv]
// Self-checking bench for float_to_decimal_text: drives single-precision words and
// checks every text character, end flag and status against an in-bench conversion.
// Depends on ftd_pkg and the float_to_decimal_text module.
`timescale 1ns / 1ps

module float_to_decimal_text_test;
  import ftd_pkg::*;

  localparam int TEXT_BYTES  = TEXT_BUFFER_BYTES_DEF;
  localparam int FRAC_DIGITS = MAX_FRACTION_DIGITS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 60;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic [WORD_W-1:0] word;
    int                gap;
    bit                drain;
  } word_req_t;

  typedef struct {
    ftd_result_t       res;
    logic [WORD_W-1:0] word;
  } char_exp_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              push         = 1'b0;
  logic              pop          = 1'b0;
  logic [WORD_W-1:0] float_bits_i = '0;
  logic              full;
  logic              empty;
  logic [CHAR_W-1:0] out_char_o;
  logic              last_char_o;
  logic [1:0]        conv_status_o;

  word_req_t word_q[$];
  char_exp_t char_q[$];
  bit        req_fire  = 1'b0;
  bit        res_fire  = 1'b0;
  int        send_hold = 0;
  int        pop_stall = 0;
  int        char_count = 0;
  int        quiet_cycles = 0;
  int        err_count = 0;

  float_to_decimal_text dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .float_bits_i (float_bits_i),
    .empty        (empty),
    .pop          (pop),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .conv_status_o(conv_status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic void push_char(input logic [WORD_W-1:0] w, input logic [CHAR_W-1:0] ch,
                                    input logic last, input ftd_status_e st);
    char_exp_t c;
    c.word       = w;
    c.res.ch     = ch;
    c.res.last   = last;
    c.res.status = st;
    char_q.push_back(c);
  endfunction

  // Builds the expected text of one word and queues its characters.
  function automatic void predict_text(input logic [WORD_W-1:0] w);
    int                e;
    int                n;
    int                r;
    int                maxd;
    logic [31:0]       mant;
    logic [31:0]       ipart;
    logic [23:0]       frac;
    logic [27:0]       prod;
    logic [3:0]        rev[0:11];
    logic [CHAR_W-1:0] txt[0:47];
    e     = int'(w[30:23]) - EXP_BIAS;
    mant  = {8'h00, 1'b1, w[22:0]};
    ipart = '0;
    frac  = '0;
    n     = 0;
    if (w[30:0] == '0) begin
      txt[0] = CH_ZERO;
      txt[1] = CH_DOT;
      txt[2] = CH_ZERO;
      n = 3;
    end else if (e >= EXP_MAX) begin
      push_char(w, CH_NONE, 1'b1, ST_LARGE);
      return;
    end else if (e < EXP_MIN) begin
      push_char(w, CH_NONE, 1'b1, ST_SMALL);
      return;
    end else begin
      if (e >= 23) begin
        ipart = mant << (e - 23);
      end else if (e >= 0) begin
        ipart = mant >> (23 - e);
        frac  = 24'(mant << (e + 1));
      end else begin
        frac = 24'(mant >> (-(e + 1)));
      end
      if (w[31]) begin
        txt[n] = CH_MINUS;
        n++;
      end
      if (ipart == '0) begin
        txt[n] = CH_ZERO;
        n++;
      end else begin
        r = 0;
        while (ipart != '0 && r < 12) begin
          rev[r] = 4'(ipart % 10);
          ipart  = ipart / 10;
          r++;
        end
        while (r > 0) begin
          r--;
          txt[n] = CH_ZERO + 7'(rev[r]);
          n++;
        end
      end
      txt[n] = CH_DOT;
      n++;
      if (frac == '0) begin
        txt[n] = CH_ZERO;
        n++;
      end else begin
        maxd = TEXT_BYTES - n - 1;
        if (maxd > FRAC_DIGITS) maxd = FRAC_DIGITS;
        if (maxd > RESULT_LIMIT - n) maxd = RESULT_LIMIT - n;
        if (maxd < 1) maxd = 1;
        for (int i = 0; i < maxd; i++) begin
          prod   = {4'h0, frac} * 28'd10;
          txt[n] = CH_ZERO + 7'(prod[27:24]);
          frac   = prod[23:0];
          n++;
        end
        while (txt[n-1] == CH_ZERO && txt[n-2] != CH_DOT) n--;
      end
    end
    if (n > RESULT_LIMIT) n = RESULT_LIMIT;
    for (int i = 0; i < n; i++) begin
      push_char(w, txt[i], (i == n - 1), ST_OK);
    end
  endfunction

  function automatic logic [WORD_W-1:0] draw_word();
    logic [7:0] ef;
    logic [7:0] edges[6];
    edges = '{8'd103, 8'd104, 8'd157, 8'd158, 8'd0, 8'd255};
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        ef = edges[$urandom_range(0, 5)];
        return {1'($urandom), ef, 23'($urandom)};
      end
      2: return {1'($urandom), 31'h0};
      default: begin
        ef = 8'($urandom_range(104, 157));
        return {1'($urandom), ef, 23'($urandom)};
      end
    endcase
  endfunction

  // Sampling side: request and result acceptance, checking, and the watchdog.
  always @(posedge clk_i) begin : sample_blk
    char_exp_t want;
    bit        req_ok;
    bit        res_ok;
    req_ok = rst_ni && push && !full;
    res_ok = rst_ni && pop && !empty;
    req_fire <= req_ok;
    res_fire <= res_ok;
    if (req_ok) begin
      predict_text(float_bits_i);
    end
    if (res_ok) begin
      char_count++;
      if (char_q.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b status %0d",
                                  out_char_o, last_char_o, conv_status_o));
      end else begin
        want = char_q.pop_front();
        if (out_char_o !== want.res.ch || last_char_o !== want.res.last ||
            conv_status_o !== want.res.status) begin
          report_mismatch($sformatf("word %h: char %h last %b status %0d, want %h %b %0d",
                                    want.word, out_char_o, last_char_o, conv_status_o,
                                    want.res.ch, want.res.last, want.res.status));
        end
      end
    end
    if (req_ok || res_ok) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Request driver.
  always @(negedge clk_i) begin : drive_blk
    logic              nxt_push;
    logic [WORD_W-1:0] nxt_word;
    nxt_push = push;
    nxt_word = float_bits_i;
    if (rst_ni) begin
      if (push && req_fire) begin
        void'(word_q.pop_front());
        nxt_push = 1'b0;
        if (word_q.size() > 0) send_hold = word_q[0].gap;
      end else if (!push && send_hold > 0) begin
        send_hold--;
      end
      if (!nxt_push && send_hold == 0 && word_q.size() > 0) begin
        if (!word_q[0].drain || char_q.size() == 0) begin
          nxt_push = 1'b1;
          nxt_word = word_q[0].word;
        end
      end
    end
    push         <= nxt_push;
    float_bits_i <= nxt_word;
  end

  // Result receiver; every third stretch of 32 characters runs without stalls.
  always @(negedge clk_i) begin : pop_blk
    logic nxt_pop;
    nxt_pop = pop;
    if (rst_ni) begin
      if (pop && res_fire) begin
        pop_stall = ((char_count % 96) >= 64) ? 0 : $urandom_range(0, 14);
        if (pop_stall > 0) nxt_pop = 1'b0;
      end else if (!pop) begin
        if (pop_stall > 0) pop_stall--;
        if (pop_stall == 0) nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  initial begin : stim_blk
    logic [WORD_W-1:0] directed[$];
    word_req_t         r;
    directed = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000,
      32'h4EFF_FFFF, 32'hCEFF_FFFF, 32'h4F00_0000, 32'h7F7F_FFFF, 32'h3380_0000,
      32'h3400_0000, 32'hB4FF_FFFF, 32'h3DCC_CCCD, 32'h3EAA_AAAB, 32'h4B7F_FFFF,
      32'h4AFF_FFFF, 32'h3F7F_FFFF, 32'h42C8_0000, 32'hC049_0FDB, 32'h3F00_0000
    };
    foreach (directed[i]) begin
      r.word  = directed[i];
      r.gap   = $urandom_range(0, 14);
      r.drain = (i == 12);
      word_q.push_back(r);
    end
    for (int i = 0; i < 75; i++) begin
      r.word  = draw_word();
      r.gap   = (i >= 40 && i < 60) ? 0 : $urandom_range(0, 14);
      r.drain = (i == 50) || ($urandom_range(0, 19) == 0);
      word_q.push_back(r);
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (word_q.size() > 0 || char_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (char_q.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", char_q.size()));
    end
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
